FILE: src/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Used by deq_ctrl, deq_dp and double_ended_queue; no dependencies.
package deq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int VALUE_W     = 32;
    localparam int OPCODE_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic load_now;   // load output register with an immediate result
        logic load_read;  // load output register from the memory read data
    } t_ctrl_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic empty;
    } t_dp_stat;

endpackage

FILE: src/deq_ctrl.sv
// Controller state machine for the double-ended queue.
// Depends on deq_pkg; drives commands into deq_dp.
module deq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  deq_pkg::t_opcode      i_opcode,
    input  logic                  i_m_tready,
    input  deq_pkg::t_dp_stat     i_stat,
    output logic                  o_s_tready,
    output logic                  o_m_tvalid,
    output deq_pkg::t_ctrl_cmd    o_cmd
);

    deq_pkg::t_state r_state;
    deq_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;
    logic            is_pop;

    assign out_free = !r_out_valid || i_m_tready;
    assign is_pop   = (i_opcode == deq_pkg::OP_POP_FRONT) || (i_opcode == deq_pkg::OP_POP_BACK);

    // Outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                o_s_tready     = out_free;
                o_cmd.accept   = i_s_tvalid && out_free;
                o_cmd.load_now = o_cmd.accept && !(is_pop && !i_stat.empty);
            end
            deq_pkg::S_READ: begin
                o_cmd.load_read = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (o_cmd.accept && !o_cmd.load_now) begin
                    n_state = deq_pkg::S_READ;
                end
            end
            deq_pkg::S_READ: begin
                n_state = deq_pkg::S_IDLE;
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_now || o_cmd.load_read) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

`ifndef ASSERT_OFF
    a_read_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == deq_pkg::S_READ) |-> !r_out_valid)
        else $error("output register busy while a pop read is in flight");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_out_valid || (r_state == deq_pkg::S_READ)))
        else $error("accepted beat produced no result path");

    a_no_accept_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == deq_pkg::S_READ) |-> !o_s_tready)
        else $error("input ready during pop read");
`endif

endmodule

FILE: src/deq_dp.sv
// Datapath for the double-ended queue: slot memory, head and count, output register.
// Depends on deq_pkg; driven by commands from deq_ctrl.
module deq_dp #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  deq_pkg::t_ctrl_cmd                i_cmd,
    input  deq_pkg::t_opcode                  i_opcode,
    input  logic signed [deq_pkg::VALUE_W-1:0] i_push_value,
    output deq_pkg::t_dp_stat                 o_stat,
    output logic signed [deq_pkg::VALUE_W-1:0] o_popped_value,
    output deq_pkg::t_status                  o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    logic [deq_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [deq_pkg::VALUE_W-1:0] r_rd_data;
    logic [AW-1:0]               r_head;
    logic [AW-1:0]               n_head;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic signed [deq_pkg::VALUE_W-1:0] r_out_data;
    deq_pkg::t_status            r_out_status;

    logic                        empty;
    logic                        full;
    logic [AW-1:0]               head_dec;
    logic [AW-1:0]               head_inc;
    logic [SW-1:0]               tail_sum;
    logic [SW-1:0]               last_sum;
    logic [AW-1:0]               tail_idx;
    logic [AW-1:0]               last_idx;
    logic [AW-1:0]               addr;
    logic                        do_write;
    logic                        do_read;
    deq_pkg::t_status            imm_status;

    assign empty = (r_count == '0);
    assign full  = (r_count == DEPTH_C);

    assign head_dec = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);

    // Wrap the back positions into range with one compare and subtract.
    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign last_sum = tail_sum - SW'(1);
    assign tail_idx = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
    assign last_idx = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        addr       = r_head;
        do_write   = 1'b0;
        do_read    = 1'b0;
        imm_status = deq_pkg::ST_OK;
        case (i_opcode)
            deq_pkg::OP_PUSH_FRONT: begin
                addr = head_dec;
                if (full) begin
                    imm_status = deq_pkg::ST_FULL;
                end else begin
                    do_write = 1'b1;
                    n_head   = head_dec;
                    n_count  = r_count + CW'(1);
                end
            end
            deq_pkg::OP_PUSH_BACK: begin
                addr = tail_idx;
                if (full) begin
                    imm_status = deq_pkg::ST_FULL;
                end else begin
                    do_write = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                addr = r_head;
                if (empty) begin
                    imm_status = deq_pkg::ST_EMPTY;
                end else begin
                    do_read = 1'b1;
                    n_head  = head_inc;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                addr = last_idx;
                if (empty) begin
                    imm_status = deq_pkg::ST_EMPTY;
                end else begin
                    do_read = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && do_write) begin
            r_mem[addr] <= i_push_value;
        end
        if (i_cmd.accept && do_read) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_now) begin
            r_out_data   <= '0;
            r_out_status <= imm_status;
        end else if (i_cmd.load_read) begin
            r_out_data   <= r_rd_data;
            r_out_status <= deq_pkg::ST_OK;
        end
    end

    assign o_stat.empty   = empty;
    assign o_popped_value = r_out_data;
    assign o_status       = r_out_status;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("element count beyond depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LAST_IDX)
        else $error("head index out of range");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.accept |=> $stable(r_count))
        else $error("count moved without an accepted beat");
`endif

endmodule

FILE: src/double_ended_queue.sv
// Double-ended queue of signed 32-bit values, top level.
// Instantiates deq_ctrl and deq_dp; uses deq_pkg.
//
// Usage:
//   Input stream: one beat per operation. i_s_tdata carries opcode and
//   push_value (push front, push back, pop front, pop back).
//   Output stream: exactly one beat per input beat, in order, carrying the
//   popped value (zero for pushes and failed pops) and a status of ok,
//   empty (pop on empty) or full (push on full, nothing stored).
//   Result path: a push or a failed pop loads the output register straight
//   from the input beat; a successful pop first reads the slot memory into
//   its registered read port and then loads the output register from it.
//   Throughput: one push per cycle while the receiver keeps up; a successful
//   pop holds off the next input beat while its memory read is in flight.
//   The output register holds a result while the receiver stalls; the next
//   input beat is taken in the cycle that result leaves.
//   Reset (i_rst_n low, synchronous) empties the queue and drops any pending
//   result. Slot contents are not cleared.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [1:0] opcode, [33:2] push_value, [39:34] zero
    input  logic [deq_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [31:0] popped_value, [33:32] status, [39:34] zero
    output logic [deq_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    deq_pkg::t_ctrl_cmd                 cmd;
    deq_pkg::t_dp_stat                  stat;
    deq_pkg::t_opcode                   opcode;
    logic signed [deq_pkg::VALUE_W-1:0] push_value;
    logic signed [deq_pkg::VALUE_W-1:0] popped_value;
    deq_pkg::t_status                   status;

    assign opcode     = deq_pkg::t_opcode'(i_s_tdata[deq_pkg::OPCODE_W-1:0]);
    assign push_value = i_s_tdata[deq_pkg::OPCODE_W +: deq_pkg::VALUE_W];

    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_opcode   (opcode),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (opcode),
        .i_push_value   (push_value),
        .o_stat         (stat),
        .o_popped_value (popped_value),
        .o_status       (status)
    );

    assign o_m_tdata = {
        (deq_pkg::OUT_TDATA_W - deq_pkg::VALUE_W - deq_pkg::STATUS_W)'(0),
        status,
        popped_value
    };

endmodule
